>>> hw/rtl/giqe_pkg.sv
// Shared types and constants for the graph incidence query engine.
// No dependencies; imported by every module of the block.
package giqe_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES    = 512;

   localparam int ACTION_W   = 3;
   localparam int EDGE_IDX_W = 10;
   localparam int VERTEX_W   = 7;
   localparam int VALUE_W    = 10;

   localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_EDGE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DEGREE    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_ADJACENT  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_NEIGHBORS = 3'd4;

   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_EDGE_COUNT   = 1'b1;

   localparam logic [VERTEX_W-1:0]   VERTEX_COUNT_RST = 7'd64;
   localparam logic [EDGE_IDX_W-1:0] EDGE_COUNT_RST   = 10'd0;

   localparam logic [VALUE_W-1:0] DEGREE_MAX = 10'd1023;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               is_empty;
      logic               last;
   } rsp_beat_type;

endpackage

>>> hw/rtl/graph_incidence_query_engine.sv
// Top level of the graph incidence query engine: ports, config registers,
// result register. Depends on giqe_pkg, giqe_row_store, giqe_engine.
//
//   channel  | dir | handshake           | payload
//   req_     | in  | req_tvalid/tready   | tdata: edge_index, vertex_a, vertex_b; tuser: action
//   rsp_     | out | rsp_tvalid/tready   | tdata: value; tuser: is_empty; tlast: last
//   csr_     | in  | csr_we              | csr_index, csr_wdata
//
// Busy after the accepting edge: a valid add edge reads the row at accept, writes it next cycle;
// clear writes all MAX_EDGES rows, one row per cycle; degree/adjacent walk the m rows in use,
// then give the result beat. Neighbors: walk, scan of n vertices in use, last beat.
// Result beats wait while rsp_tready is low and the output register is full; the engine stays busy.
// After reset a clearing pass over all MAX_EDGES rows runs before req_tready rises.
module graph_incidence_query_engine
   import giqe_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // edge_index[9:0], vertex_a[16:10], vertex_b[23:17]
   input  logic [ACTION_W-1:0]   req_tuser,  // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // value[9:0], zero fill
   output logic                  rsp_tuser,  // is_empty
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [EDGE_IDX_W-1:0] csr_wdata
);

   localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int VW = $clog2(MAX_VERTICES);

   logic [VERTEX_W-1:0]     vcount_ff, vcount_in;
   logic [EDGE_IDX_W-1:0]   ecount_ff, ecount_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   rsp_beat_type            rsp_beat_ff, rsp_beat_in;

   logic                    ready, take, out_free, emit;
   rsp_beat_type            beat;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr, mem_raddr;
   logic [MAX_VERTICES-1:0] mem_wdata, mem_rdata;

   assign req_tready = ready;
   assign take       = req_tvalid & ready;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   always_comb begin
      vcount_in = vcount_ff;
      ecount_in = ecount_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_in = csr_wdata[VERTEX_W-1:0];
            CSR_EDGE_COUNT:   ecount_in = csr_wdata;
            default:          vcount_in = vcount_ff;
         endcase
      end
      rsp_vld_in  = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
      rsp_beat_in = emit ? beat : rsp_beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff  <= VERTEX_COUNT_RST;
         ecount_ff  <= EDGE_COUNT_RST;
         rsp_vld_ff <= 1'b0;
      end else begin
         vcount_ff  <= vcount_in;
         ecount_ff  <= ecount_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(16 - VALUE_W){1'b0}}, rsp_beat_ff.value};
   assign rsp_tuser  = rsp_beat_ff.is_empty;
   assign rsp_tlast  = rsp_beat_ff.last;

   giqe_row_store #(
      .ROW_W (MAX_VERTICES),
      .DEPTH (MAX_EDGES),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   giqe_engine #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .AW           (AW),
      .VW           (VW)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_take     (take),
      .req_action   (req_tuser),
      .req_edge     (req_tdata[9:0]),
      .req_va       (req_tdata[16:10]),
      .req_vb       (req_tdata[23:17]),
      .vertex_count (vcount_ff),
      .edge_count   (ecount_ff),
      .ready        (ready),
      .out_free     (out_free),
      .emit         (emit),
      .beat         (beat),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata)
   );

endmodule

>>> hw/rtl/giqe_row_store.sv
// Incidence row memory: one write port, one read port, registered read data.
// Depends on giqe_pkg.
module giqe_row_store
   import giqe_pkg::*;
#(
   parameter int ROW_W = DEF_MAX_VERTICES,
   parameter int DEPTH = DEF_MAX_EDGES,
   parameter int AW    = 9
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [ROW_W-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [ROW_W-1:0] rdata
);

   logic [ROW_W-1:0] mem [DEPTH];
   logic [ROW_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/giqe_engine.sv
// Sequencer and shared row unit: clear sweep, add read-modify-write,
// row walk for queries and neighbor scan. Depends on giqe_pkg.
module giqe_engine
   import giqe_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES,
   parameter int AW           = 9,
   parameter int VW           = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_take,
   input  logic [ACTION_W-1:0]     req_action,
   input  logic [EDGE_IDX_W-1:0]   req_edge,
   input  logic [VERTEX_W-1:0]     req_va,
   input  logic [VERTEX_W-1:0]     req_vb,
   input  logic [VERTEX_W-1:0]     vertex_count,
   input  logic [EDGE_IDX_W-1:0]   edge_count,
   output logic                    ready,
   input  logic                    out_free,
   output logic                    emit,
   output rsp_beat_type            beat,
   output logic                    mem_we,
   output logic [AW-1:0]           mem_waddr,
   output logic [MAX_VERTICES-1:0] mem_wdata,
   output logic [AW-1:0]           mem_raddr,
   input  logic [MAX_VERTICES-1:0] mem_rdata
);

   localparam int PW   = AW + 1;
   localparam int CMPW = (PW > EDGE_IDX_W) ? PW : EDGE_IDX_W;
   localparam int MV   = MAX_VERTICES;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CLEAR = 7'b0000010,
      S_ADD   = 7'b0000100,
      S_WALK  = 7'b0001000,
      S_SCAN  = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_HOLD  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [PW-1:0]       ptr_ff, ptr_in;
   logic                rdv_ff, rdv_in;
   logic [ACTION_W-1:0] op_ff, op_in;
   logic [MV-1:0]       mask_a_ff, mask_a_in;
   logic [MV-1:0]       mask_b_ff, mask_b_in;
   logic                adj_ok_ff, adj_ok_in;
   logic [VALUE_W-1:0]  count_ff, count_in;
   logic                found_ff, found_in;
   logic [MV-1:0]       reach_ff, reach_in;
   logic [VW:0]         vidx_ff, vidx_in;
   logic [VW-1:0]       pend_ff, pend_in;
   logic                pend_vld_ff, pend_vld_in;
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic                res_empty_ff, res_empty_in;

   logic [VERTEX_W-1:0] n_used;
   logic [PW-1:0]       m_used;
   logic                a_ok, b_ok, e_ok;
   logic [VERTEX_W-1:0] a_m1, b_m1;
   logic [MV-1:0]       bit_a, bit_b;
   logic [CMPW-1:0]     e_wide, e_m1;
   logic                issue;
   logic                hit_a, hit_both, scan_bit;
   logic [MV-1:0]       both;

   assign n_used = (vertex_count > VERTEX_W'(MV)) ? VERTEX_W'(MV) : vertex_count;
   assign m_used = (CMPW'(edge_count) > CMPW'(MAX_EDGES)) ? PW'(MAX_EDGES)
                                                           : PW'(edge_count);

   assign a_ok  = (req_va != '0) && (req_va <= n_used);
   assign b_ok  = (req_vb != '0) && (req_vb <= n_used);
   assign a_m1  = req_va - VERTEX_W'(1);
   assign b_m1  = req_vb - VERTEX_W'(1);
   assign bit_a = a_ok ? (MV'(1) << a_m1[VW-1:0]) : '0;
   assign bit_b = b_ok ? (MV'(1) << b_m1[VW-1:0]) : '0;

   assign e_wide = CMPW'(req_edge);
   assign e_m1   = e_wide - CMPW'(1);
   assign e_ok   = (req_edge != '0) && (e_wide <= CMPW'(MAX_EDGES));

   assign both     = mask_a_ff | mask_b_ff;
   assign hit_a    = |(mem_rdata & mask_a_ff);
   assign hit_both = adj_ok_ff && ((mem_rdata & both) == both);
   assign issue    = (ptr_ff < m_used);
   assign scan_bit = reach_ff[vidx_ff[VW-1:0]] & ~mask_a_ff[vidx_ff[VW-1:0]];

   assign ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      rdv_in       = 1'b0;
      op_in        = op_ff;
      mask_a_in    = mask_a_ff;
      mask_b_in    = mask_b_ff;
      adj_ok_in    = adj_ok_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      reach_in     = reach_ff;
      vidx_in      = vidx_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      res_value_in = res_value_ff;
      res_empty_in = res_empty_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff[AW-1:0];
      mem_wdata    = '0;
      mem_raddr    = ptr_ff[AW-1:0];
      emit         = 1'b0;
      beat         = '{value: res_value_ff, is_empty: res_empty_ff, last: 1'b1};

      case (state_ff)
         S_IDLE: begin
            mem_raddr = e_m1[AW-1:0];
            if (req_take) begin
               op_in     = req_action;
               mask_a_in = bit_a;
               mask_b_in = bit_b;
               adj_ok_in = a_ok && b_ok && (req_va != req_vb);
               ptr_in    = '0;
               count_in  = '0;
               found_in  = 1'b0;
               reach_in  = '0;
               case (req_action)
                  ACT_CLEAR: begin
                     state_in = S_CLEAR;
                  end
                  ACT_ADD_EDGE: begin
                     ptr_in = PW'(e_m1[AW-1:0]);
                     if (e_ok && a_ok && b_ok) begin
                        state_in = S_ADD;
                     end
                  end
                  ACT_DEGREE, ACT_ADJACENT, ACT_NEIGHBORS: begin
                     state_in = S_WALK;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + PW'(1);
            if (ptr_ff == PW'(MAX_EDGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | mask_a_ff | mask_b_ff;
            state_in  = S_IDLE;
         end
         S_WALK: begin
            rdv_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + PW'(1);
            end
            if (rdv_ff) begin
               if (hit_a && (count_ff != DEGREE_MAX)) begin
                  count_in = count_ff + VALUE_W'(1);
               end
               if (hit_both) begin
                  found_in = 1'b1;
               end
               if (hit_a) begin
                  reach_in = reach_ff | mem_rdata;
               end
            end
            if (!issue && !rdv_ff) begin
               res_empty_in = 1'b0;
               vidx_in      = '0;
               pend_vld_in  = 1'b0;
               case (op_ff)
                  ACT_DEGREE: begin
                     res_value_in = count_ff;
                     state_in     = S_EMIT;
                  end
                  ACT_ADJACENT: begin
                     res_value_in = VALUE_W'(found_ff);
                     state_in     = S_EMIT;
                  end
                  default: begin
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            beat = '{value: VALUE_W'(pend_ff) + VALUE_W'(1), is_empty: 1'b0, last: 1'b0};
            if (VERTEX_W'(vidx_ff) < n_used) begin
               if (scan_bit) begin
                  if (!pend_vld_ff) begin
                     pend_vld_in = 1'b1;
                     pend_in     = vidx_ff[VW-1:0];
                     vidx_in     = vidx_ff + (VW+1)'(1);
                  end else if (out_free) begin
                     emit    = 1'b1;
                     pend_in = vidx_ff[VW-1:0];
                     vidx_in = vidx_ff + (VW+1)'(1);
                  end
               end else begin
                  vidx_in = vidx_ff + (VW+1)'(1);
               end
            end else begin
               res_value_in = pend_vld_ff ? VALUE_W'(pend_ff) + VALUE_W'(1) : '0;
               res_empty_in = !pend_vld_ff;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff   <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         rdv_ff   <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      mask_a_ff    <= mask_a_in;
      mask_b_ff    <= mask_b_in;
      adj_ok_ff    <= adj_ok_in;
      count_ff     <= count_in;
      found_ff     <= found_in;
      reach_ff     <= reach_in;
      vidx_ff      <= vidx_in;
      pend_ff      <= pend_in;
      pend_vld_ff  <= pend_vld_in;
      res_value_ff <= res_value_in;
      res_empty_ff <= res_empty_in;
   end

endmodule
